// ===== src/bmpc_pkg.sv =====
// Package for the button menu press classifier: register indexes, reset
// values of the timing registers and the auto-repeat period function.
// No dependencies.
`default_nettype none

package bmpc_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_IDLE_TIMEOUT  = 3'd0,
        CFG_LONG_PRESS    = 3'd1,
        CFG_SHORT_MIN     = 3'd2,
        CFG_REPEAT_BASE   = 3'd3,
        CFG_PAGE_CONFIRM  = 3'd4,
        CFG_RESET_HOLD    = 3'd5
    } t_cfg_index;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int TIME_W       = 32;
    localparam int PAGE_W       = 3;
    localparam int PAGE_COUNT_DEF = 2;

    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10000;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [15:0] SHORT_MIN_RST    = 16'd50;
    localparam logic [15:0] REPEAT_BASE_RST  = 16'd300;
    localparam logic [15:0] PAGE_CONFIRM_RST = 16'd200;
    localparam logic [19:0] RESET_HOLD_RST   = 20'd30000;

    // Hold-time tiers of the auto-repeat and their periods.
    localparam logic [31:0] HOLD_TIER_FAST = 32'd5000;
    localparam logic [31:0] HOLD_TIER_MID  = 32'd3000;
    localparam logic [31:0] HOLD_TIER_SLOW = 32'd1000;
    localparam logic [15:0] PERIOD_FAST    = 16'd20;
    localparam logic [15:0] PERIOD_MID     = 16'd50;
    localparam logic [15:0] PERIOD_SLOW    = 16'd100;

    // The repeat period shrinks the longer the button has been held.
    function automatic logic [15:0] repeat_period(input logic [31:0] hold,
                                                  input logic [15:0] base);
        logic [15:0] period;
        if (hold > HOLD_TIER_FAST) begin
            period = PERIOD_FAST;
        end else if (hold > HOLD_TIER_MID) begin
            period = PERIOD_MID;
        end else if (hold > HOLD_TIER_SLOW) begin
            period = PERIOD_SLOW;
        end else begin
            period = base;
        end
        return period;
    endfunction

endpackage

`default_nettype wire

// ===== src/button_menu_press_classifier.sv =====
// Button menu press classifier: input register, one pass of classification
// logic and a result register. Depends on bmpc_pkg.
//
//   channel  direction  handshake              payload
//   input    in         i_in_valid/o_in_stall  i_now_ms, i_*_pressed
//   result   out        o_out_valid/i_out_stall  o_move_up .. o_reset_request
//   config   in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One beat per cycle while the result is not stalled; a beat accepted into the
// input register moves on into the result register when the result can advance.
// The classification of a beat reads and updates the mode and button state
// in the same cycle that moves it into the result register.
// A stalled result holds the input register, which then stalls the input.
// Reset (synchronous, active low) restores page mode, page 0 and the default
// timing registers; the config port is always ready.
`default_nettype none

module button_menu_press_classifier #(
    parameter int PAGE_COUNT = bmpc_pkg::PAGE_COUNT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [bmpc_pkg::TIME_W-1:0]      i_now_ms,
    input  wire logic                             i_up_pressed,
    input  wire logic                             i_down_pressed,
    input  wire logic                             i_select_pressed,

    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_move_up,
    output logic                                  o_move_down,
    output logic                                  o_select_event,
    output logic                                  o_back_event,
    output logic                                  o_menu_open,
    output logic                                  o_menu_opened,
    output logic                                  o_menu_timed_out,
    output logic [bmpc_pkg::PAGE_W-1:0]           o_page_index,
    output logic                                  o_page_changed,
    output logic                                  o_reset_request,

    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [bmpc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [bmpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [3:0] PcLast = 4'(PAGE_COUNT - 1);
    localparam logic [3:0] PcW    = 4'(PAGE_COUNT);

    // Configuration registers.
    logic [15:0] r_idle_timeout, r_long_press, r_short_min;
    logic [15:0] r_repeat_base, r_page_confirm;
    logic [19:0] r_reset_hold;

    // Input register.
    logic        r_in_valid;
    logic [31:0] r_now;
    logic        r_up, r_down, r_sel;

    // Classification state.
    logic        r_menu, n_menu;
    logic [2:0]  r_page, n_page;
    logic        r_up_held, n_up_held, r_down_held, n_down_held;
    logic        r_sel_held, n_sel_held, r_sel_long, n_sel_long;
    logic [1:0]  r_step_done, n_step_done;
    logic [31:0] r_up_start, n_up_start, r_up_last, n_up_last;
    logic [31:0] r_down_start, n_down_start, r_down_last, n_down_last;
    logic [31:0] r_sel_start, n_sel_start, r_last_act, n_last_act;

    // Result of the current beat.
    logic n_mv_up, n_mv_dn, n_sel_ev, n_back_ev, n_opened, n_timed_out;
    logic n_changed, n_rst_req;

    logic adv, in_fire;

    assign adv        = r_in_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= bmpc_pkg::IDLE_TIMEOUT_RST;
            r_long_press   <= bmpc_pkg::LONG_PRESS_RST;
            r_short_min    <= bmpc_pkg::SHORT_MIN_RST;
            r_repeat_base  <= bmpc_pkg::REPEAT_BASE_RST;
            r_page_confirm <= bmpc_pkg::PAGE_CONFIRM_RST;
            r_reset_hold   <= bmpc_pkg::RESET_HOLD_RST;
        end else if (i_cfg_valid) begin
            case (bmpc_pkg::t_cfg_index'(i_cfg_index))
                bmpc_pkg::CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data[15:0];
                bmpc_pkg::CFG_LONG_PRESS:   r_long_press   <= i_cfg_data[15:0];
                bmpc_pkg::CFG_SHORT_MIN:    r_short_min    <= i_cfg_data[15:0];
                bmpc_pkg::CFG_REPEAT_BASE:  r_repeat_base  <= i_cfg_data[15:0];
                bmpc_pkg::CFG_PAGE_CONFIRM: r_page_confirm <= i_cfg_data[15:0];
                bmpc_pkg::CFG_RESET_HOLD:   r_reset_hold   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_now  <= i_now_ms;
            r_up   <= i_up_pressed;
            r_down <= i_down_pressed;
            r_sel  <= i_select_pressed;
        end
    end

    always_comb begin
        logic        v_any, v_open;
        logic [31:0] v_dt;
        logic [3:0]  v_pg;

        n_menu       = r_menu;
        n_page       = r_page;
        n_up_held    = r_up_held;
        n_down_held  = r_down_held;
        n_sel_held   = r_sel_held;
        n_sel_long   = r_sel_long;
        n_step_done  = r_step_done;
        n_up_start   = r_up_start;
        n_up_last    = r_up_last;
        n_down_start = r_down_start;
        n_down_last  = r_down_last;
        n_sel_start  = r_sel_start;
        n_last_act   = r_last_act;
        n_mv_up      = 1'b0;
        n_mv_dn      = 1'b0;
        n_sel_ev     = 1'b0;
        n_back_ev    = 1'b0;
        n_opened     = 1'b0;
        n_timed_out  = 1'b0;
        n_changed    = 1'b0;
        n_rst_req    = 1'b0;
        v_any        = 1'b0;
        v_open       = 1'b0;
        v_dt         = '0;
        v_pg         = {1'b0, r_page};

        if (r_menu) begin
            // Up: event on press, then auto-repeat.
            if (!r_up) begin
                n_up_held = 1'b0;
            end else if (!r_up_held) begin
                n_up_held  = 1'b1;
                n_up_start = r_now;
                n_up_last  = r_now;
                n_mv_up    = 1'b1;
            end else if (r_now - r_up_last > 32'(bmpc_pkg::repeat_period(
                         r_now - r_up_start, r_repeat_base))) begin
                n_up_last = r_now;
                n_mv_up   = 1'b1;
            end

            if (!r_down) begin
                n_down_held = 1'b0;
            end else if (!r_down_held) begin
                n_down_held  = 1'b1;
                n_down_start = r_now;
                n_down_last  = r_now;
                n_mv_dn      = 1'b1;
            end else if (r_now - r_down_last > 32'(bmpc_pkg::repeat_period(
                         r_now - r_down_start, r_repeat_base))) begin
                n_down_last = r_now;
                n_mv_dn     = 1'b1;
            end

            if (r_sel) begin
                if (!r_sel_held) begin
                    n_sel_held  = 1'b1;
                    n_sel_start = r_now;
                    n_sel_long  = 1'b0;
                end
                if (!n_sel_long && (r_now - n_sel_start >= 32'(r_long_press))) begin
                    n_back_ev  = 1'b1;
                    n_sel_long = 1'b1;
                end
            end else begin
                v_dt = r_now - r_sel_start;
                if (r_sel_held && !r_sel_long && (v_dt >= 32'(r_short_min))
                    && (v_dt < 32'(r_long_press))) begin
                    n_sel_ev = 1'b1;
                end
                n_sel_held = 1'b0;
                n_sel_long = 1'b0;
            end

            v_any = n_mv_up || n_mv_dn || n_sel_ev || n_back_ev;
            if (v_any) begin
                n_last_act = r_now;
            end
            if (r_now - n_last_act >= 32'(r_idle_timeout)) begin
                n_menu      = 1'b0;
                n_timed_out = 1'b1;
                n_up_held   = 1'b0;
                n_down_held = 1'b0;
                n_sel_held  = 1'b0;
                n_sel_long  = 1'b0;
                n_step_done = 2'b00;
            end
        end else begin
            // Page mode: one step per press held past the confirm time.
            if (!r_up) begin
                n_up_held      = 1'b0;
                n_step_done[0] = 1'b0;
            end else begin
                if (!r_up_held) begin
                    n_up_held      = 1'b1;
                    n_up_start     = r_now;
                    n_step_done[0] = 1'b0;
                end
                if (!n_step_done[0] && (r_now - n_up_start >= 32'(r_page_confirm))) begin
                    n_step_done[0] = 1'b1;
                    n_changed      = 1'b1;
                    v_pg = (v_pg == 4'd0) ? PcLast : v_pg - 4'd1;
                end
            end

            if (!r_down) begin
                n_down_held    = 1'b0;
                n_step_done[1] = 1'b0;
            end else begin
                if (!r_down_held) begin
                    n_down_held    = 1'b1;
                    n_down_start   = r_now;
                    n_step_done[1] = 1'b0;
                end
                if (!n_step_done[1] && (r_now - n_down_start >= 32'(r_page_confirm))) begin
                    n_step_done[1] = 1'b1;
                    n_changed      = 1'b1;
                    v_pg = (v_pg + 4'd1 >= PcW) ? 4'd0 : v_pg + 4'd1;
                end
            end
            n_page = v_pg[2:0];

            if (r_sel) begin
                if (!r_sel_held) begin
                    n_sel_held  = 1'b1;
                    n_sel_start = r_now;
                    n_sel_long  = 1'b0;
                end
                if (r_now - n_sel_start >= 32'(r_reset_hold)) begin
                    n_rst_req  = 1'b1;
                    n_sel_long = 1'b1;
                end
            end else begin
                v_dt = r_now - r_sel_start;
                v_open = r_sel_held && !r_sel_long && (v_dt >= 32'(r_short_min))
                         && (v_dt < 32'(r_long_press));
                n_sel_held = 1'b0;
                n_sel_long = 1'b0;
                if (v_open) begin
                    n_menu      = 1'b1;
                    n_opened    = 1'b1;
                    n_last_act  = r_now;
                    n_up_held   = 1'b0;
                    n_down_held = 1'b0;
                    n_step_done = 2'b00;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu       <= 1'b0;
            r_page       <= '0;
            r_up_held    <= 1'b0;
            r_down_held  <= 1'b0;
            r_sel_held   <= 1'b0;
            r_sel_long   <= 1'b0;
            r_step_done  <= 2'b00;
            r_up_start   <= '0;
            r_up_last    <= '0;
            r_down_start <= '0;
            r_down_last  <= '0;
            r_sel_start  <= '0;
            r_last_act   <= '0;
        end else if (adv) begin
            r_menu       <= n_menu;
            r_page       <= n_page;
            r_up_held    <= n_up_held;
            r_down_held  <= n_down_held;
            r_sel_held   <= n_sel_held;
            r_sel_long   <= n_sel_long;
            r_step_done  <= n_step_done;
            r_up_start   <= n_up_start;
            r_up_last    <= n_up_last;
            r_down_start <= n_down_start;
            r_down_last  <= n_down_last;
            r_sel_start  <= n_sel_start;
            r_last_act   <= n_last_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_move_up        <= n_mv_up;
            o_move_down      <= n_mv_dn;
            o_select_event   <= n_sel_ev;
            o_back_event     <= n_back_ev;
            o_menu_open      <= n_menu;
            o_menu_opened    <= n_opened;
            o_menu_timed_out <= n_timed_out;
            o_page_index     <= n_page;
            o_page_changed   <= n_changed;
            o_reset_request  <= n_rst_req;
        end
    end

    // A result that opens the menu reports it open; a timeout reports it shut.
    a_open_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_menu_opened |-> o_menu_open)
        else $error("menu_opened without menu_open");

    a_timeout_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_menu_timed_out |-> !o_menu_open && !o_menu_opened)
        else $error("menu_timed_out while menu reported open");

    // Menu events and page events never mix in one result.
    a_mode_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_move_up || o_move_down || o_select_event || o_back_event)
        |-> !o_page_changed && !o_reset_request)
        else $error("menu and page events in one result");

    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_page_index} < PcW))
        else $error("page index beyond page count");

    // The stored beat moves on whenever the result register can take it.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !(o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("input beat not advanced");

endmodule

`default_nettype wire

// ===== sim/tb_button_menu_press_classifier.sv =====
// Testbench for button_menu_press_classifier: directed and random button traffic,
// random idling on both channels, and an in-order predictor of every result beat.
// Depends on bmpc_pkg and the button_menu_press_classifier RTL.
module tb_button_menu_press_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES         = bmpc_pkg::PAGE_COUNT_DEF;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASE_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam int DIR_UP   = 0;
    localparam int DIR_DOWN = 1;

    localparam logic [2:0] BTN_NONE = 3'b000;
    localparam logic [2:0] BTN_UP   = 3'b001;
    localparam logic [2:0] BTN_DOWN = 3'b010;
    localparam logic [2:0] BTN_SEL  = 3'b100;

    // Register indexes past the end of the map; writes to them must be dropped.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic       move_up;
        logic       move_down;
        logic       select_event;
        logic       back_event;
        logic       menu_open;
        logic       menu_opened;
        logic       menu_timed_out;
        logic [2:0] page_index;
        logic       page_changed;
        logic       reset_request;
    } t_panel_out;

    typedef struct {
        logic [15:0] idle_timeout;
        logic [15:0] long_press;
        logic [15:0] short_min;
        logic [15:0] repeat_base;
        logic [15:0] page_confirm;
        logic [19:0] reset_hold;
    } t_timing;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_now_ms = '0;
    logic        i_up_pressed = 1'b0;
    logic        i_down_pressed = 1'b0;
    logic        i_select_pressed = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_move_up;
    logic        o_move_down;
    logic        o_select_event;
    logic        o_back_event;
    logic        o_menu_open;
    logic        o_menu_opened;
    logic        o_menu_timed_out;
    logic [2:0]  o_page_index;
    logic        o_page_changed;
    logic        o_reset_request;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;

    button_menu_press_classifier #(
        .PAGE_COUNT(PAGES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_now_ms         (i_now_ms),
        .i_up_pressed     (i_up_pressed),
        .i_down_pressed   (i_down_pressed),
        .i_select_pressed (i_select_pressed),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_move_up        (o_move_up),
        .o_move_down      (o_move_down),
        .o_select_event   (o_select_event),
        .o_back_event     (o_back_event),
        .o_menu_open      (o_menu_open),
        .o_menu_opened    (o_menu_opened),
        .o_menu_timed_out (o_menu_timed_out),
        .o_page_index     (o_page_index),
        .o_page_changed   (o_page_changed),
        .o_reset_request  (o_reset_request),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: timing registers, mode and per-button tracking.
    t_timing     tm;
    logic        menu_on;
    logic [2:0]  page_no;
    logic        dir_held [2];
    logic [31:0] dir_start [2];
    logic [31:0] dir_last [2];
    logic [1:0]  steps_done;
    logic        sel_held;
    logic        sel_long;
    logic [31:0] sel_start;
    logic [31:0] last_act;

    t_panel_out  awaited_panel [$];
    logic [19:0] timing_words [0:5];
    logic [31:0] clock_ms = '0;
    int unsigned items_sent = 0;
    int unsigned fail_count = 0;
    int unsigned cycles = 0;
    bit          no_idle = 1'b0;

    function automatic void apply_reg(input logic [2:0] idx, input logic [19:0] data);
        case (idx)
            bmpc_pkg::CFG_IDLE_TIMEOUT: tm.idle_timeout = data[15:0];
            bmpc_pkg::CFG_LONG_PRESS:   tm.long_press   = data[15:0];
            bmpc_pkg::CFG_SHORT_MIN:    tm.short_min    = data[15:0];
            bmpc_pkg::CFG_REPEAT_BASE:  tm.repeat_base  = data[15:0];
            bmpc_pkg::CFG_PAGE_CONFIRM: tm.page_confirm = data[15:0];
            bmpc_pkg::CFG_RESET_HOLD:   tm.reset_hold   = data;
            default: ;
        endcase
    endfunction

    function automatic void drop_tracking();
        dir_held[DIR_UP] = 1'b0;
        dir_held[DIR_DOWN] = 1'b0;
        sel_held = 1'b0;
        sel_long = 1'b0;
        steps_done = 2'b00;
    endfunction

    // Menu mode: one event on press, then repeats whose period shrinks with hold time.
    function automatic logic menu_repeat(input logic [31:0] now, input logic pressed,
                                         input int b);
        logic [31:0] hold;
        logic [31:0] since;
        logic [31:0] period;
        if (!pressed) begin
            dir_held[b] = 1'b0;
            return 1'b0;
        end
        if (!dir_held[b]) begin
            dir_held[b] = 1'b1;
            dir_start[b] = now;
            dir_last[b] = now;
            return 1'b1;
        end
        hold = now - dir_start[b];
        since = now - dir_last[b];
        if (hold > bmpc_pkg::HOLD_TIER_FAST) begin
            period = 32'(bmpc_pkg::PERIOD_FAST);
        end else if (hold > bmpc_pkg::HOLD_TIER_MID) begin
            period = 32'(bmpc_pkg::PERIOD_MID);
        end else if (hold > bmpc_pkg::HOLD_TIER_SLOW) begin
            period = 32'(bmpc_pkg::PERIOD_SLOW);
        end else begin
            period = 32'(tm.repeat_base);
        end
        if (since > period) begin
            dir_last[b] = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Page mode: a single step once the press has lasted the confirm time.
    function automatic logic page_step(input logic [31:0] now, input logic pressed,
                                       input int b);
        logic [31:0] hold;
        if (!pressed) begin
            dir_held[b] = 1'b0;
            steps_done[b] = 1'b0;
            return 1'b0;
        end
        if (!dir_held[b]) begin
            dir_held[b] = 1'b1;
            dir_start[b] = now;
            steps_done[b] = 1'b0;
        end
        hold = now - dir_start[b];
        if (!steps_done[b] && hold >= 32'(tm.page_confirm)) begin
            steps_done[b] = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_panel_out classify_buttons(input logic [31:0] now,
                                                    input logic [2:0] btn);
        t_panel_out  r;
        logic        busy;
        logic        open_now;
        logic [31:0] held_for;
        int unsigned pg;
        r = '0;
        if (menu_on) begin
            busy = 1'b0;
            if (menu_repeat(now, btn[0], DIR_UP)) begin
                r.move_up = 1'b1;
                busy = 1'b1;
            end
            if (menu_repeat(now, btn[1], DIR_DOWN)) begin
                r.move_down = 1'b1;
                busy = 1'b1;
            end
            if (btn[2]) begin
                if (!sel_held) begin
                    sel_held = 1'b1;
                    sel_start = now;
                    sel_long = 1'b0;
                end
                held_for = now - sel_start;
                if (!sel_long && held_for >= 32'(tm.long_press)) begin
                    r.back_event = 1'b1;
                    sel_long = 1'b1;
                    busy = 1'b1;
                end
            end else begin
                held_for = now - sel_start;
                if (sel_held && !sel_long && held_for >= 32'(tm.short_min)
                        && held_for < 32'(tm.long_press)) begin
                    r.select_event = 1'b1;
                    busy = 1'b1;
                end
                sel_held = 1'b0;
                sel_long = 1'b0;
            end
            if (busy) begin
                last_act = now;
            end
            held_for = now - last_act;
            if (held_for >= 32'(tm.idle_timeout)) begin
                menu_on = 1'b0;
                r.menu_timed_out = 1'b1;
                drop_tracking();
            end
        end else begin
            pg = page_no % PAGES;
            // Up steps the page index down and down steps it up; both may apply.
            if (page_step(now, btn[0], DIR_UP)) begin
                pg = (pg == 0) ? PAGES - 1 : pg - 1;
                r.page_changed = 1'b1;
            end
            if (page_step(now, btn[1], DIR_DOWN)) begin
                pg = (pg + 1 >= PAGES) ? 0 : pg + 1;
                r.page_changed = 1'b1;
            end
            page_no = pg[2:0];
            if (btn[2]) begin
                if (!sel_held) begin
                    sel_held = 1'b1;
                    sel_start = now;
                    sel_long = 1'b0;
                end
                held_for = now - sel_start;
                if (held_for >= 32'(tm.reset_hold)) begin
                    r.reset_request = 1'b1;
                    sel_long = 1'b1;
                end
            end else begin
                held_for = now - sel_start;
                open_now = sel_held && !sel_long && held_for >= 32'(tm.short_min)
                           && held_for < 32'(tm.long_press);
                sel_held = 1'b0;
                sel_long = 1'b0;
                if (open_now) begin
                    menu_on = 1'b1;
                    r.menu_opened = 1'b1;
                    last_act = now;
                    drop_tracking();
                end
            end
        end
        r.menu_open = menu_on;
        r.page_index = page_no;
        return r;
    endfunction

    function automatic bit take_gap();
        return !no_idle && ($urandom_range(99) < 36);
    endfunction

    task automatic send_tick(input logic [31:0] now, input logic [2:0] btn);
        while (take_gap()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ms <= now;
        i_up_pressed <= btn[0];
        i_down_pressed <= btn[1];
        i_select_pressed <= btn[2];
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        awaited_panel.push_back(classify_buttons(now, btn));
        items_sent++;
    endtask

    task automatic tick(input logic [2:0] btn, input logic [31:0] adv);
        clock_ms = clock_ms + adv;
        send_tick(clock_ms, btn);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited_panel.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Leaves the write valid high so that back-to-back writes need no second assignment.
    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        apply_reg(idx, data);
    endtask

    task automatic load_timing();
        write_reg(bmpc_pkg::CFG_IDLE_TIMEOUT, timing_words[bmpc_pkg::CFG_IDLE_TIMEOUT]);
        write_reg(bmpc_pkg::CFG_LONG_PRESS, timing_words[bmpc_pkg::CFG_LONG_PRESS]);
        write_reg(bmpc_pkg::CFG_SHORT_MIN, timing_words[bmpc_pkg::CFG_SHORT_MIN]);
        write_reg(bmpc_pkg::CFG_REPEAT_BASE, timing_words[bmpc_pkg::CFG_REPEAT_BASE]);
        write_reg(bmpc_pkg::CFG_PAGE_CONFIRM, timing_words[bmpc_pkg::CFG_PAGE_CONFIRM]);
        write_reg(bmpc_pkg::CFG_RESET_HOLD, timing_words[bmpc_pkg::CFG_RESET_HOLD]);
        i_cfg_valid <= 1'b0;
    endtask

    // Narrow registers get random upper bits that the block must discard.
    function automatic logic [19:0] pick_ms(input int unsigned span, input bit wide);
        logic [19:0] w;
        case ($urandom_range(7))
            0: w = '0;
            1: w = '1;
            default: begin
                w = 20'($urandom_range(0, span));
                if (!wide) begin
                    w[19:16] = 4'($urandom_range(15));
                end
            end
        endcase
        return w;
    endfunction

    function automatic logic [31:0] hold_step();
        case ($urandom_range(19))
            0:          return $urandom;
            1, 2:       return $urandom_range(1000, 6000);
            3, 4, 5, 6: return $urandom_range(100, 1500);
            default:    return $urandom_range(0, 120);
        endcase
    endfunction

    function automatic logic [31:0] near_limit(input logic [19:0] limit);
        logic [31:0] base;
        base = 32'(limit);
        return base + $urandom_range(2) - 1;
    endfunction

    function automatic logic [31:0] tap_inside();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = 32'(tm.short_min);
        hi = 32'(tm.long_press);
        if (hi > lo) begin
            return lo + $urandom_range(0, hi - lo - 1);
        end
        return lo;
    endfunction

    task automatic gesture();
        int unsigned n;
        logic [2:0]  dir;
        dir = ($urandom_range(5) == 0) ? (BTN_UP | BTN_DOWN)
              : ($urandom_range(1) ? BTN_UP : BTN_DOWN);
        case ($urandom_range(11))
            0, 1, 2: begin
                n = $urandom_range(1, 30);
                repeat (n) tick(dir, hold_step());
                tick(BTN_NONE, hold_step());
            end
            3: begin
                tick(BTN_SEL, $urandom_range(0, 200));
                tick(BTN_NONE, near_limit($urandom_range(1) ? 20'(tm.short_min)
                                                            : 20'(tm.long_press)));
            end
            4, 5: begin
                tick(BTN_SEL, $urandom_range(0, 200));
                tick(BTN_NONE, tap_inside());
            end
            6: begin
                tick(BTN_SEL, $urandom_range(0, 200));
                tick(BTN_SEL, near_limit($urandom_range(1) ? 20'(tm.long_press)
                                                           : tm.reset_hold));
                tick(BTN_SEL, $urandom_range(0, 50));
                tick(BTN_NONE, $urandom_range(0, 50));
            end
            7: begin
                tick(dir, $urandom_range(0, 100));
                tick(dir, near_limit(20'(tm.page_confirm)));
                tick(BTN_NONE, $urandom_range(0, 100));
            end
            8: begin
                tick(BTN_NONE, $urandom_range(1) ? near_limit(20'(tm.idle_timeout))
                                                 : $urandom_range(0, 20000));
            end
            9: begin
                n = $urandom_range(1, 4);
                repeat (n) tick(3'($urandom_range(7)), $urandom);
            end
            default: begin
                n = $urandom_range(1, 8);
                repeat (n) tick(3'($urandom_range(7)), hold_step());
            end
        endcase
    endtask

    task automatic test_menu_navigation();
        tick(BTN_NONE, 0);
        tick(BTN_SEL, 100);
        tick(BTN_NONE, 200);
        tick(BTN_UP, 10);
        tick(BTN_UP, 390);
        tick(BTN_DOWN, 10);
        tick(BTN_SEL, 10);
        tick(BTN_SEL, 1080);
        tick(BTN_NONE, 100);
        tick(BTN_SEL, 50);
        tick(BTN_NONE, 150);
        tick(BTN_NONE, 10100);
    endtask

    task automatic test_page_mode();
        tick(BTN_UP | BTN_DOWN, 100);
        tick(BTN_UP | BTN_DOWN, 300);
        tick(BTN_NONE, 10);
        tick(BTN_SEL, 10);
        tick(BTN_SEL, 30000);
        tick(BTN_NONE, 100);
        // Hold across the 32-bit wrap of the timestamp.
        clock_ms = 32'hFFFF_FFFF;
        tick(BTN_UP, 0);
        tick(BTN_UP, 300);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '0);
        timing_words[bmpc_pkg::CFG_IDLE_TIMEOUT] = '0;
        timing_words[bmpc_pkg::CFG_LONG_PRESS] = '1;
        timing_words[bmpc_pkg::CFG_SHORT_MIN] = '0;
        timing_words[bmpc_pkg::CFG_REPEAT_BASE] = '0;
        timing_words[bmpc_pkg::CFG_PAGE_CONFIRM] = '0;
        timing_words[bmpc_pkg::CFG_RESET_HOLD] = '1;
        load_timing();
        tick(BTN_SEL, 5);
        tick(BTN_NONE, 0);
        // With a zero idle timeout the menu closes on its first tick.
        tick(BTN_UP, 1);
        wait_idle();
        timing_words[bmpc_pkg::CFG_RESET_HOLD] = '0;
        load_timing();
        tick(BTN_SEL, 5);
        tick(BTN_NONE, 5);
    endtask

    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned phase_end;
        int unsigned stop_at;
        phase = 0;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            wait_idle();
            case (phase)
                0: begin
                    timing_words[bmpc_pkg::CFG_IDLE_TIMEOUT] =
                        20'(bmpc_pkg::IDLE_TIMEOUT_RST);
                    timing_words[bmpc_pkg::CFG_LONG_PRESS] = 20'(bmpc_pkg::LONG_PRESS_RST);
                    timing_words[bmpc_pkg::CFG_SHORT_MIN] = 20'(bmpc_pkg::SHORT_MIN_RST);
                    timing_words[bmpc_pkg::CFG_REPEAT_BASE] = 20'(bmpc_pkg::REPEAT_BASE_RST);
                    timing_words[bmpc_pkg::CFG_PAGE_CONFIRM] =
                        20'(bmpc_pkg::PAGE_CONFIRM_RST);
                    timing_words[bmpc_pkg::CFG_RESET_HOLD] = bmpc_pkg::RESET_HOLD_RST;
                end
                1: begin
                    foreach (timing_words[i]) timing_words[i] = '1;
                end
                2: begin
                    foreach (timing_words[i]) timing_words[i] = '0;
                end
                default: begin
                    timing_words[bmpc_pkg::CFG_IDLE_TIMEOUT] = pick_ms(15000, 1'b0);
                    timing_words[bmpc_pkg::CFG_LONG_PRESS] = pick_ms(2000, 1'b0);
                    timing_words[bmpc_pkg::CFG_SHORT_MIN] = pick_ms(200, 1'b0);
                    timing_words[bmpc_pkg::CFG_REPEAT_BASE] = pick_ms(400, 1'b0);
                    timing_words[bmpc_pkg::CFG_PAGE_CONFIRM] = pick_ms(500, 1'b0);
                    timing_words[bmpc_pkg::CFG_RESET_HOLD] = pick_ms(40000, 1'b1);
                end
            endcase
            load_timing();
            if (phase % 3 == 2) begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(20000);
            end
            no_idle = (phase == 3);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                gesture();
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(99) < 36);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_button_menu_press_classifier: errors");
            $finish;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_panel_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_panel.size() == 0) begin
                fail_count++;
                $error("result beat with no prediction waiting");
            end else begin
                want = awaited_panel.pop_front();
                check_field("move_up", 32'(want.move_up), 32'(o_move_up));
                check_field("move_down", 32'(want.move_down), 32'(o_move_down));
                check_field("select_event", 32'(want.select_event), 32'(o_select_event));
                check_field("back_event", 32'(want.back_event), 32'(o_back_event));
                check_field("menu_open", 32'(want.menu_open), 32'(o_menu_open));
                check_field("menu_opened", 32'(want.menu_opened), 32'(o_menu_opened));
                check_field("menu_timed_out", 32'(want.menu_timed_out),
                            32'(o_menu_timed_out));
                check_field("page_index", 32'(want.page_index), 32'(o_page_index));
                check_field("page_changed", 32'(want.page_changed), 32'(o_page_changed));
                check_field("reset_request", 32'(want.reset_request),
                            32'(o_reset_request));
            end
        end
    end

    initial begin
        tm.idle_timeout = bmpc_pkg::IDLE_TIMEOUT_RST;
        tm.long_press = bmpc_pkg::LONG_PRESS_RST;
        tm.short_min = bmpc_pkg::SHORT_MIN_RST;
        tm.repeat_base = bmpc_pkg::REPEAT_BASE_RST;
        tm.page_confirm = bmpc_pkg::PAGE_CONFIRM_RST;
        tm.reset_hold = bmpc_pkg::RESET_HOLD_RST;
        menu_on = 1'b0;
        page_no = '0;
        dir_held[DIR_UP] = 1'b0;
        dir_held[DIR_DOWN] = 1'b0;
        dir_start[DIR_UP] = '0;
        dir_start[DIR_DOWN] = '0;
        dir_last[DIR_UP] = '0;
        dir_last[DIR_DOWN] = '0;
        steps_done = '0;
        sel_held = 1'b0;
        sel_long = 1'b0;
        sel_start = '0;
        last_act = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_menu_navigation();
        test_page_mode();
        test_register_extremes();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && awaited_panel.size() == 0) begin
            $display("tb_button_menu_press_classifier: clean");
        end else begin
            $display("tb_button_menu_press_classifier: errors");
        end
        $finish;
    end

endmodule

// ===== button_menu_press_classifier.f =====
src/bmpc_pkg.sv
src/button_menu_press_classifier.sv
sim/tb_button_menu_press_classifier.sv
